>>> hw/rtl/timed_frame_delay_selector_assert.svh
// Assertion macros used by the checker of the frame delay selector.
`ifndef TIMED_FRAME_DELAY_SELECTOR_ASSERT_SVH
`define TIMED_FRAME_DELAY_SELECTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TFDS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tfds assertion failed: %m");

// Next-cycle implication, disabled during reset.
`define TFDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tfds assertion failed: %m");

`endif

>>> hw/rtl/tfds_pkg.sv
// Package: types, constants and helper functions of the frame delay selector.
package tfds_pkg;

   localparam int FRAME_SLOTS = 32;
   localparam int SLOT_W      = $clog2(FRAME_SLOTS);
   localparam int CNT_W       = $clog2(FRAME_SLOTS + 1);
   localparam int TIME_W      = 32;
   localparam int ALPHA_W     = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [CNT_W-1:0]      count_type;
   typedef logic [TIME_W-1:0]     time_type;
   typedef logic [ALPHA_W-1:0]    alpha_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // register indexes
   localparam csr_idx_type REG_DELAY_TIME  = csr_idx_type'(0);
   localparam csr_idx_type REG_BLUR_ENABLE = csr_idx_type'(1);

   localparam time_type  DELAY_RESET = time_type'(500);
   localparam alpha_type ALPHA_ONE   = alpha_type'(16384);
   localparam alpha_type ALPHA_TWO   = alpha_type'(32768);

   // slot store write and read requests
   typedef struct packed {
      logic     en;
      slot_type slot;
      time_type stamp;
   } slot_wr_type;

   typedef struct packed {
      logic     en;
      slot_type slot;
   } slot_rd_type;

   function automatic slot_type next_slot(input slot_type s);
      return (s == slot_type'(FRAME_SLOTS - 1)) ? '0 : s + slot_type'(1);
   endfunction

   function automatic slot_type prev_slot(input slot_type s);
      return (s == '0) ? slot_type'(FRAME_SLOTS - 1) : s - slot_type'(1);
   endfunction

   // 2.0 in Q2.14 divided by the frame count, truncated
   function automatic alpha_type alpha_of(input count_type n);
      alpha_type a;
      case (n)
         count_type'(1):  a = alpha_type'(32768);
         count_type'(2):  a = alpha_type'(16384);
         count_type'(3):  a = alpha_type'(10922);
         count_type'(4):  a = alpha_type'(8192);
         count_type'(5):  a = alpha_type'(6553);
         count_type'(6):  a = alpha_type'(5461);
         count_type'(7):  a = alpha_type'(4681);
         count_type'(8):  a = alpha_type'(4096);
         count_type'(9):  a = alpha_type'(3640);
         count_type'(10): a = alpha_type'(3276);
         count_type'(11): a = alpha_type'(2978);
         count_type'(12): a = alpha_type'(2730);
         count_type'(13): a = alpha_type'(2520);
         count_type'(14): a = alpha_type'(2340);
         count_type'(15): a = alpha_type'(2184);
         count_type'(16): a = alpha_type'(2048);
         count_type'(17): a = alpha_type'(1927);
         count_type'(18): a = alpha_type'(1820);
         count_type'(19): a = alpha_type'(1724);
         count_type'(20): a = alpha_type'(1638);
         count_type'(21): a = alpha_type'(1560);
         count_type'(22): a = alpha_type'(1489);
         count_type'(23): a = alpha_type'(1424);
         count_type'(24): a = alpha_type'(1365);
         count_type'(25): a = alpha_type'(1310);
         count_type'(26): a = alpha_type'(1260);
         count_type'(27): a = alpha_type'(1213);
         count_type'(28): a = alpha_type'(1170);
         count_type'(29): a = alpha_type'(1129);
         count_type'(30): a = alpha_type'(1092);
         count_type'(31): a = alpha_type'(1057);
         count_type'(32): a = alpha_type'(1024);
         default:         a = '0;
      endcase
      return a;
   endfunction

endpackage

>>> hw/rtl/tfds_slot_store.sv
// Timestamp ring memory with per-slot valid bits and a registered read port.
module tfds_slot_store (
   input  logic                  clock,
   input  logic                  reset,
   input  tfds_pkg::slot_wr_type wr,
   input  tfds_pkg::slot_rd_type rd,
   output tfds_pkg::time_type    rd_stamp
);
   import tfds_pkg::*;

   time_type               slot_mem_ff [FRAME_SLOTS];
   logic [FRAME_SLOTS-1:0] slot_valid_ff;
   time_type               rd_data_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         slot_mem_ff[wr.slot] <= wr.stamp;
      end
      if (rd.en) begin
         rd_data_ff  <= slot_mem_ff[rd.slot];
         rd_valid_ff <= slot_valid_ff[rd.slot];
      end
   end

   // never-written slots read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (wr.en) begin
         slot_valid_ff[wr.slot] <= 1'b1;
      end
   end

   assign rd_stamp = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> hw/rtl/timed_frame_delay_selector.sv
// Timed frame delay selector: top level with sequencer, ring walk and result register.
// With delay_time zero an accepted item goes straight to FIN, otherwise through WALK;
// the walk reads one ring slot per cycle through the single memory read port.
// req_ready is high only while the sequencer is idle, so a new item waits until the last
// result is loaded; a result still waiting for rsp_ready holds the next one in FIN.
// Reset (synchronous): delay_time 500, blur off, write/read slots zero, all slot valid
// bits cleared at once so every slot reads as timestamp zero; no clearing pass.
module timed_frame_delay_selector (
   input  logic                   clock,
   input  logic                   reset,
   // input items
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tfds_pkg::time_type     req_frame_time,
   // result items
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tfds_pkg::slot_type     rsp_store_slot,
   output tfds_pkg::slot_type     rsp_show_slot,
   output tfds_pkg::count_type    rsp_blend_count,
   output tfds_pkg::alpha_type    rsp_blend_alpha,
   // configuration writes
   input  logic                   csr_we,
   input  tfds_pkg::csr_idx_type  csr_index,
   input  tfds_pkg::csr_data_type csr_wdata
);
   import tfds_pkg::*;

   // IDLE: waiting for an item; WALK: scanning the ring; FIN: building the result
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // configuration
   time_type delay_time_ff;
   logic     blur_enable_ff;

   // ring pointers
   slot_type write_slot_ff, write_slot_in;
   slot_type read_slot_ff,  read_slot_in;

   // walk context
   time_type  now_ff,       now_in;
   slot_type  show_slot_ff, show_slot_in;
   slot_type  rd_slot_ff,   rd_slot_in;    // next slot to issue
   slot_type  rx_slot_ff,   rx_slot_in;    // slot whose data lands next
   count_type issue_cnt_ff, issue_cnt_in;
   count_type rx_cnt_ff,    rx_cnt_in;
   logic      pend_ff,      pend_in;       // read in flight
   logic      prev_old_ff,  prev_old_in;   // previous slot was at least delay old

   // result register
   logic      rsp_valid_ff,  rsp_valid_in;
   slot_type  rsp_store_ff,  rsp_store_in;
   slot_type  rsp_show_ff,   rsp_show_in;
   count_type rsp_count_ff,  rsp_count_in;
   alpha_type rsp_alpha_ff,  rsp_alpha_in;

   slot_wr_type slot_wr;
   slot_rd_type slot_rd;
   time_type    rd_stamp;

   logic      accept;
   logic      load;
   time_type  age;
   logic      cur_old;
   count_type span;
   count_type count_val;

   tfds_slot_store u_slot_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (slot_wr),
      .rd       (slot_rd),
      .rd_stamp (rd_stamp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign load      = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   // the one compare unit: age of the slot just read against the delay
   assign age     = now_ff - rd_stamp;
   assign cur_old = (age >= delay_time_ff);

   // frames from show slot to write slot, modulo the ring size
   always_comb begin
      span = count_type'(write_slot_ff) - count_type'(show_slot_ff);
      if (write_slot_ff < show_slot_ff) begin
         span = span + count_type'(FRAME_SLOTS);
      end
      count_val = span + count_type'(1);
   end

   always_comb begin
      state_in      = state_ff;
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      now_in        = now_ff;
      show_slot_in  = show_slot_ff;
      rd_slot_in    = rd_slot_ff;
      rx_slot_in    = rx_slot_ff;
      issue_cnt_in  = issue_cnt_ff;
      rx_cnt_in     = rx_cnt_ff;
      pend_in       = 1'b0;
      prev_old_in   = prev_old_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_store_in  = rsp_store_ff;
      rsp_show_in   = rsp_show_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_alpha_in  = rsp_alpha_ff;

      slot_wr.en    = 1'b0;
      slot_wr.slot  = write_slot_ff;
      slot_wr.stamp = req_frame_time;
      slot_rd.en    = 1'b0;
      slot_rd.slot  = rd_slot_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // store first, so the walk sees the new frame in its slot
               slot_wr.en = 1'b1;
               now_in     = req_frame_time;
               if (delay_time_ff == '0) begin
                  show_slot_in = write_slot_ff;
                  state_in     = ST_FIN;
               end else begin
                  show_slot_in = read_slot_ff;
                  rd_slot_in   = next_slot(read_slot_ff);
                  rx_slot_in   = next_slot(read_slot_ff);
                  issue_cnt_in = '0;
                  rx_cnt_in    = '0;
                  prev_old_in  = 1'b0;
                  state_in     = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // issue one read per cycle, the whole ring ending at the old show slot
            if (issue_cnt_ff < count_type'(FRAME_SLOTS)) begin
               slot_rd.en   = 1'b1;
               rd_slot_in   = next_slot(rd_slot_ff);
               issue_cnt_in = issue_cnt_ff + count_type'(1);
               pend_in      = 1'b1;
            end
            if (pend_ff) begin
               if ((rx_cnt_ff != '0) && prev_old_ff && !cur_old) begin
                  // previous slot is old enough, this one is younger: stop there
                  show_slot_in = prev_slot(rx_slot_ff);
                  pend_in      = 1'b0;
                  state_in     = ST_FIN;
               end else if (rx_cnt_ff == count_type'(FRAME_SLOTS - 1)) begin
                  // back at the old show slot, no match: keep it
                  pend_in  = 1'b0;
                  state_in = ST_FIN;
               end else begin
                  prev_old_in = cur_old;
                  rx_cnt_in   = rx_cnt_ff + count_type'(1);
                  rx_slot_in  = next_slot(rx_slot_ff);
               end
            end
         end
         ST_FIN: begin
            if (load) begin
               rsp_valid_in  = 1'b1;
               rsp_store_in  = write_slot_ff;
               rsp_show_in   = show_slot_ff;
               rsp_count_in  = blur_enable_ff ? count_val : count_type'(1);
               rsp_alpha_in  = blur_enable_ff ? alpha_of(count_val) : ALPHA_ONE;
               read_slot_in  = show_slot_ff;
               write_slot_in = next_slot(write_slot_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // walk context and result payload
   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      show_slot_ff <= show_slot_in;
      rd_slot_ff   <= rd_slot_in;
      rx_slot_ff   <= rx_slot_in;
      issue_cnt_ff <= issue_cnt_in;
      rx_cnt_ff    <= rx_cnt_in;
      prev_old_ff  <= prev_old_in;
      rsp_store_ff <= rsp_store_in;
      rsp_show_ff  <= rsp_show_in;
      rsp_count_ff <= rsp_count_in;
      rsp_alpha_ff <= rsp_alpha_in;
   end

   // configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_time_ff  <= DELAY_RESET;
         blur_enable_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_DELAY_TIME:  delay_time_ff  <= time_type'(csr_wdata);
            REG_BLUR_ENABLE: blur_enable_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_store_slot  = rsp_store_ff;
   assign rsp_show_slot   = rsp_show_ff;
   assign rsp_blend_count = rsp_count_ff;
   assign rsp_blend_alpha = rsp_alpha_ff;

endmodule

>>> hw/rtl/tfds_checker.sv
// Port-level checker of the frame delay selector and its bind to the top level.
`include "timed_frame_delay_selector_assert.svh"

module tfds_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input tfds_pkg::slot_type  rsp_store_slot,
   input tfds_pkg::slot_type  rsp_show_slot,
   input tfds_pkg::count_type rsp_blend_count,
   input tfds_pkg::alpha_type rsp_blend_alpha
);
   import tfds_pkg::*;

   logic [2*SLOT_W+CNT_W+ALPHA_W-1:0] rsp_payload;
   logic                              rsp_stall;
   logic                              count_ok;
   logic                              single_frame;
   logic                              single_alpha_ok;

   assign rsp_payload     = {rsp_store_slot, rsp_show_slot, rsp_blend_count, rsp_blend_alpha};
   assign rsp_stall       = rsp_valid && !rsp_ready;
   assign count_ok        = (rsp_blend_count != '0) &&
                            (rsp_blend_count <= count_type'(FRAME_SLOTS));
   assign single_frame    = rsp_valid && (rsp_blend_count == count_type'(1));
   assign single_alpha_ok = (rsp_blend_alpha == ALPHA_ONE) || (rsp_blend_alpha == ALPHA_TWO);

   // a stalled result holds
   `TFDS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // the sequencer is busy in the cycle after an accept
   `TFDS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // frame count stays within the ring
   `TFDS_ASSERT_IMPLY(a_count_range, clock, reset, rsp_valid, count_ok)

   // single frame: alpha is 1.0 (blur off) or 2.0 (blur on)
   `TFDS_ASSERT_IMPLY(a_single_alpha, clock, reset, single_frame, single_alpha_ok)

endmodule

bind timed_frame_delay_selector tfds_checker u_tfds_checker (.*);
